### rtl/core/crnc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crnc_pkg: shared definitions for the cell reference notation converter
// Character codes, parse phases, segment sources and the control/status
// bundles that run between the controller and the datapath.
// ----------------------------------------------------------------------------
package crnc_pkg;

  localparam logic [1:0] PH_LETTERS = 2'd0;
  localparam logic [1:0] PH_DIGITS  = 2'd1;
  localparam logic [1:0] PH_BREAK   = 2'd2;

  localparam logic [7:0] CH_A = 8'h41;
  localparam logic [7:0] CH_Z = 8'h5A;
  localparam logic [7:0] CH_0 = 8'h30;
  localparam logic [7:0] CH_9 = 8'h39;
  localparam logic [7:0] CH_R = 8'h52;
  localparam logic [7:0] CH_C = 8'h43;

  localparam logic [4:0] RADIX_DEC = 5'd10;
  localparam logic [4:0] RADIX_LET = 5'd26;

  localparam logic [1:0] SRC_FIRST  = 2'd0;
  localparam logic [1:0] SRC_LETTER = 2'd1;
  localparam logic [1:0] SRC_SECOND = 2'd2;

  typedef struct packed {
    logic       accept;
    logic       load;
    logic [1:0] src;
    logic       letters;
    logic       div_step;
    logic       push_lit;
    logic       lit_c;
    logic       push_digit;
    logic       pop;
    logic       pop_last;
    logic       clear;
  } crnc_cmd_t;

  typedef struct packed {
    logic ld_form;
    logic second_zero;
    logic next_zero;
    logic sp_one;
    logic emit_full;
    logic out_free;
  } crnc_stat_t;

endpackage
`default_nettype wire

### rtl/core/cell_reference_notation_converter.sv
`default_nettype none
// Input: one character per cycle while idle. After the final character each
// number or letter segment is loaded, then each digit or letter takes a
// quotient step and a remainder-and-push step; each character then moves to
// the output register once that is free. Literals are pushed and moved; an
// empty column is skipped. No input is taken until the last character is popped.
// Reset (synchronous, rst_n low) clears the parse state and the output valid.
// ----------------------------------------------------------------------------
// cell_reference_notation_converter: A1 / R1C1 cell reference converter
// Parses a reference one character at a time and emits the other notation
// as a run of characters, the final one marked.
// ----------------------------------------------------------------------------
module cell_reference_notation_converter import crnc_pkg::*; #(
  parameter int VALUE_BITS    = 20,
  parameter int MAX_OUT_CHARS = 16
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_char_code,
  input  wire logic       in_last_char,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_char,
  output logic            out_last
);

  crnc_cmd_t  cmd;
  crnc_stat_t stat;

  crnc_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_last_char (in_last_char),
    .in_ready     (in_ready),
    .stat         (stat),
    .cmd          (cmd)
  );

  crnc_dp #(
    .VALUE_BITS    (VALUE_BITS),
    .MAX_OUT_CHARS (MAX_OUT_CHARS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_char_code (in_char_code),
    .cmd          (cmd),
    .stat         (stat),
    .out_char     (out_char),
    .out_last     (out_last),
    .out_valid    (out_valid),
    .out_ready    (out_ready)
  );

endmodule
`default_nettype wire

### rtl/core/crnc_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crnc_dp: converter datapath
// Parse accumulators, a reciprocal-multiply divider by 10 or 26, a digit stack
// that reverses the remainders, and the output register.
// ----------------------------------------------------------------------------
module crnc_dp import crnc_pkg::*; #(
  parameter int VALUE_BITS    = 20,
  parameter int MAX_OUT_CHARS = 16
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic [7:0] in_char_code,
  input  wire crnc_cmd_t  cmd,
  output crnc_stat_t      stat,
  output logic [7:0]      out_char,
  output logic            out_last,
  output logic            out_valid,
  input  wire logic       out_ready
);

  localparam int AW      = VALUE_BITS + 5;
  localparam int QSH     = VALUE_BITS + 5;
  localparam int MW      = VALUE_BITS + 2;
  localparam int PW      = VALUE_BITS + MW;
  localparam int DIG_MAX = ((VALUE_BITS * 1233) >> 12) + 1;
  localparam int IW      = $clog2(DIG_MAX);
  localparam int SPW     = $clog2(DIG_MAX + 1);
  localparam int ECW     = $clog2(MAX_OUT_CHARS);

  // Rounded-up reciprocals; the rounding error stays below 2^5 over the
  // divisor, which keeps the quotient exact for every VALUE_BITS-bit value.
  localparam longint unsigned RECIP_DEC_FULL =
    ((64'd1 << QSH) + 64'(RADIX_DEC) - 64'd1) / 64'(RADIX_DEC);
  localparam longint unsigned RECIP_LET_FULL =
    ((64'd1 << QSH) + 64'(RADIX_LET) - 64'd1) / 64'(RADIX_LET);
  localparam logic [MW-1:0] RECIP_DEC = MW'(RECIP_DEC_FULL);
  localparam logic [MW-1:0] RECIP_LET = MW'(RECIP_LET_FULL);

  logic [1:0]            phase_r;
  logic                  ld_form_r;
  logic [VALUE_BITS-1:0] letter_r;
  logic [VALUE_BITS-1:0] first_r;
  logic [VALUE_BITS-1:0] second_r;

  logic [VALUE_BITS-1:0] val_r;
  logic [VALUE_BITS-1:0] quo_r;
  logic [SPW-1:0]        sp_r;
  logic [ECW-1:0]        emit_cnt_r;
  logic [7:0]            stk_r [DIG_MAX];
  logic [7:0]            out_char_r;
  logic                  out_last_r;
  logic                  out_valid_r;

  logic                  is_let;
  logic                  is_dig;
  logic                  use_letters;
  logic [VALUE_BITS-1:0] acc_sel;
  logic [4:0]            acc_base;
  logic [4:0]            acc_add;
  logic [AW-1:0]         acc_sum;
  logic [VALUE_BITS-1:0] acc_sat;

  logic [4:0]            radix;
  logic [MW-1:0]         recip;
  logic [PW-1:0]         quo_prod;
  logic [VALUE_BITS-1:0] quo_calc;
  logic [AW-1:0]         rem_full;
  logic [4:0]            rem_val;
  logic [VALUE_BITS-1:0] val_next;
  logic [VALUE_BITS-1:0] src_val;
  logic [7:0]            digit_ch;
  logic [7:0]            push_ch;
  logic [SPW-1:0]        sp_dec;

  // Character classification and the shared saturating multiply-add.
  always_comb begin
    is_let      = (in_char_code >= CH_A) && (in_char_code <= CH_Z);
    is_dig      = (in_char_code >= CH_0) && (in_char_code <= CH_9);
    use_letters = (phase_r == PH_LETTERS) && is_let;
    if (use_letters) begin
      acc_sel  = letter_r;
      acc_base = RADIX_LET;
      acc_add  = 5'(in_char_code - CH_A + 8'd1);
    end else begin
      acc_sel  = (phase_r == PH_BREAK) ? second_r : first_r;
      acc_base = RADIX_DEC;
      acc_add  = 5'(in_char_code - CH_0);
    end
    acc_sum = AW'(acc_sel) * AW'(acc_base) + AW'(acc_add);
    if (acc_sum[AW-1:VALUE_BITS] != '0) begin
      acc_sat = {VALUE_BITS{1'b1}};
    end else begin
      acc_sat = acc_sum[VALUE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      phase_r   <= PH_LETTERS;
      ld_form_r <= 1'b1;
      letter_r  <= '0;
      first_r   <= '0;
      second_r  <= '0;
    end else if (cmd.accept) begin
      case (phase_r)
        PH_LETTERS: begin
          if (is_let) begin
            letter_r <= acc_sat;
          end else if (is_dig) begin
            phase_r <= PH_DIGITS;
            first_r <= acc_sat;
          end else begin
            phase_r   <= PH_BREAK;
            ld_form_r <= 1'b0;
          end
        end
        PH_DIGITS: begin
          if (is_dig) begin
            first_r <= acc_sat;
          end else begin
            phase_r   <= PH_BREAK;
            ld_form_r <= 1'b0;
          end
        end
        default: begin
          if (is_dig) begin
            second_r <= acc_sat;
          end
        end
      endcase
    end
  end

  // The quotient is registered first; the next cycle recovers the
  // remainder from it and pushes the character.
  always_comb begin
    radix    = cmd.letters ? RADIX_LET : RADIX_DEC;
    recip    = cmd.letters ? RECIP_LET : RECIP_DEC;
    quo_prod = PW'(val_r) * PW'(recip);
    quo_calc = VALUE_BITS'(quo_prod[PW-1:QSH]);
    rem_full = AW'(val_r) - AW'(quo_r) * AW'(radix);
    rem_val  = rem_full[4:0];
    val_next = (cmd.letters && rem_val == 5'd0) ? quo_r - 1'b1 : quo_r;
    if (cmd.letters) begin
      digit_ch = (rem_val == 5'd0) ? CH_Z : CH_A + 8'(rem_val) - 8'd1;
    end else begin
      digit_ch = CH_0 + 8'(rem_val);
    end
    case (cmd.src)
      SRC_FIRST:  src_val = first_r;
      SRC_LETTER: src_val = letter_r;
      SRC_SECOND: src_val = second_r;
      default:    src_val = first_r;
    endcase
    if (cmd.push_lit) begin
      push_ch = cmd.lit_c ? CH_C : CH_R;
    end else begin
      push_ch = digit_ch;
    end
    sp_dec = sp_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      val_r <= src_val;
    end else if (cmd.push_digit) begin
      val_r <= val_next;
    end
    if (cmd.div_step) begin
      quo_r <= quo_calc;
    end
    if (cmd.push_digit || cmd.push_lit) begin
      stk_r[sp_r[IW-1:0]] <= push_ch;
    end
    if (cmd.pop) begin
      out_char_r <= stk_r[sp_dec[IW-1:0]];
      out_last_r <= cmd.pop_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r        <= '0;
      emit_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.push_digit || cmd.push_lit) begin
        sp_r <= sp_r + 1'b1;
      end else if (cmd.pop) begin
        sp_r <= sp_dec;
      end
      if (cmd.pop) begin
        emit_cnt_r <= emit_cnt_r + 1'b1;
      end
      // The end of a reference drops any characters beyond the output limit.
      if (cmd.clear) begin
        sp_r       <= '0;
        emit_cnt_r <= '0;
      end
      if (cmd.pop) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_comb begin
    stat.ld_form     = ld_form_r;
    stat.second_zero = second_r == '0;
    stat.next_zero   = val_next == '0;
    stat.sp_one      = sp_r == SPW'(1);
    stat.emit_full   = emit_cnt_r == ECW'(MAX_OUT_CHARS - 1);
    stat.out_free    = !out_valid_r || out_ready;
  end

  assign out_char  = out_char_r;
  assign out_last  = out_last_r;
  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop |-> sp_r != '0)
    else $error("pop from an empty digit stack");
  a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= SPW'(DIG_MAX))
    else $error("digit stack overflow");
  a_pop_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop |-> stat.out_free)
    else $error("pop into an occupied output register");
  a_last_shown: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop && cmd.pop_last |=> out_valid_r && out_last_r)
    else $error("final character not presented as last");
`endif

endmodule
`default_nettype wire

### rtl/core/crnc_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crnc_ctrl: converter sequencer
// Takes characters while idle, then walks the output segments of the other
// notation: literal, divide, push remainder, and pop to the output.
// ----------------------------------------------------------------------------
module crnc_ctrl import crnc_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire logic       in_last_char,
  output logic            in_ready,
  input  wire crnc_stat_t stat,
  output crnc_cmd_t       cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SEG   = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_DIGIT = 3'd3;
  localparam logic [2:0] S_POP   = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic [1:0] seg_r;
  logic [1:0] seg_nxt;

  logic       last_seg;
  logic       is_lit;
  logic       letters;
  logic       fin;

  // Letters-digits output is R, row, C, column; row-column output is
  // column letters followed by the row.
  always_comb begin
    last_seg = stat.ld_form ? (seg_r == 2'd3) : (seg_r == 2'd1);
    is_lit   = stat.ld_form && !seg_r[0];
    letters  = !stat.ld_form && (seg_r == 2'd0);
    fin      = stat.emit_full || (stat.sp_one && last_seg);
  end

  always_comb begin
    state_nxt   = state_r;
    seg_nxt     = seg_r;
    in_ready    = 1'b0;
    cmd         = '0;
    cmd.letters = letters;
    cmd.lit_c   = seg_r[1];
    if (stat.ld_form) begin
      cmd.src = seg_r[1] ? SRC_LETTER : SRC_FIRST;
    end else begin
      cmd.src = seg_r[0] ? SRC_FIRST : SRC_SECOND;
    end
    case (state_r)
      S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid && in_last_char) begin
          seg_nxt   = 2'd0;
          state_nxt = S_SEG;
        end
      end
      S_SEG: begin
        if (is_lit) begin
          cmd.push_lit = 1'b1;
          state_nxt    = S_POP;
        end else if (letters && stat.second_zero) begin
          seg_nxt = seg_r + 2'd1;
        end else begin
          cmd.load  = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        state_nxt    = S_DIGIT;
      end
      S_DIGIT: begin
        cmd.push_digit = 1'b1;
        state_nxt      = stat.next_zero ? S_POP : S_DIV;
      end
      S_POP: begin
        if (stat.out_free) begin
          cmd.pop      = 1'b1;
          cmd.pop_last = fin;
          if (fin) begin
            cmd.clear = 1'b1;
            state_nxt = S_IDLE;
          end else if (stat.sp_one) begin
            seg_nxt   = seg_r + 2'd1;
            state_nxt = S_SEG;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      seg_r   <= 2'd0;
    end else begin
      state_r <= state_nxt;
      seg_r   <= seg_nxt;
    end
  end

`ifndef SYNTHESIS
  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |-> state_r == S_IDLE && in_valid)
    else $error("character taken outside idle");
  a_one_push: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.push_lit && cmd.push_digit) && !(cmd.pop && (cmd.push_lit || cmd.push_digit)))
    else $error("conflicting stack operations");
  a_clear_with_last: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear |-> cmd.pop && cmd.pop_last)
    else $error("parse state cleared before the final character");
`endif

endmodule
`default_nettype wire

### bench/tb_cell_reference_notation_converter.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_cell_reference_notation_converter: self-checking bench for the converter
// Feeds spreadsheet cell references one character per request, predicts the
// converted notation in the bench and compares every output character in
// order. Directed references cover saturation, breaks and zero values; random
// references follow, with random gaps on both channels and one long output
// hold-off that backs the block up into its input.
// ----------------------------------------------------------------------------
module tb_cell_reference_notation_converter import crnc_pkg::*;;

  localparam int CLK_PERIOD     = 20;
  localparam int VALUE_BITS     = 20;
  localparam int MAX_OUT_CHARS  = 16;
  localparam int RANDOM_CHARS   = 222;
  localparam int HOLD_CYCLES    = 300;
  localparam int TAIL_CYCLES    = 4 * (VALUE_BITS + 2);
  localparam int WATCHDOG_LIMIT = 5000;
  localparam logic [VALUE_BITS-1:0] VALUE_MAX = '1;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } conv_char_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_char_code;
  logic       in_last_char;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_char;
  logic       out_last;

  cell_reference_notation_converter #(
    .VALUE_BITS   (VALUE_BITS),
    .MAX_OUT_CHARS(MAX_OUT_CHARS)
  ) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_char_code(in_char_code),
    .in_last_char(in_last_char),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_char    (out_char),
    .out_last    (out_last)
  );

  // Bench copy of the parse state.
  logic [1:0]            parse_phase;
  logic                  letters_first;
  logic [VALUE_BITS-1:0] letter_col;
  logic [VALUE_BITS-1:0] row_num;
  logic [VALUE_BITS-1:0] col_num;

  logic [7:0] conv_text[$];
  logic [7:0] ref_text[$];
  conv_char_t expected_chars[$];

  int  errors;
  int  chars_sent;
  int  refs_sent;
  int  results_seen;
  int  stall_cycles;
  bit  tx_idle;
  bit  rx_idle;
  bit  hold_req;
  bit  out_taken;

  initial clk = 1'b0;
  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic logic [VALUE_BITS-1:0] scale_add(input logic [VALUE_BITS-1:0] v,
                                                      input int unsigned radix,
                                                      input int unsigned digit);
    longint unsigned r;
    r = v;
    r = r * radix + digit;
    return (r > VALUE_MAX) ? VALUE_MAX : r[VALUE_BITS-1:0];
  endfunction

  task automatic append_decimal(input logic [VALUE_BITS-1:0] v);
    logic [7:0]            digits[$];
    logic [VALUE_BITS-1:0] rest;
    rest = v;
    do begin
      digits.push_front(CH_0 + 8'(rest % 10));
      rest = rest / 10;
    end while (rest != 0);
    foreach (digits[i]) conv_text.push_back(digits[i]);
  endtask

  // Bijective base 26: a zero remainder means Z and borrows one from the rest.
  task automatic append_letters(input logic [VALUE_BITS-1:0] v);
    logic [7:0]            letters[$];
    logic [VALUE_BITS-1:0] rest;
    rest = v;
    while (rest != 0) begin
      if (rest % 26 == 0) begin
        letters.push_front(CH_Z);
        rest = rest / 26 - 1;
      end else begin
        letters.push_front(CH_A + 8'(rest % 26) - 8'd1);
        rest = rest / 26;
      end
    end
    foreach (letters[i]) conv_text.push_back(letters[i]);
  endtask

  task automatic predict_conversion(input logic [7:0] ch, input logic lst);
    logic is_letter;
    logic is_digit;
    int   n;
    is_letter = (ch >= CH_A) && (ch <= CH_Z);
    is_digit  = (ch >= CH_0) && (ch <= CH_9);
    case (parse_phase)
      PH_LETTERS: begin
        if (is_letter) begin
          letter_col = scale_add(letter_col, RADIX_LET, ch - CH_A + 1);
        end else if (is_digit) begin
          parse_phase = PH_DIGITS;
          row_num = scale_add(row_num, RADIX_DEC, ch - CH_0);
        end else begin
          parse_phase = PH_BREAK;
          letters_first = 1'b0;
        end
      end
      PH_DIGITS: begin
        if (is_digit) begin
          row_num = scale_add(row_num, RADIX_DEC, ch - CH_0);
        end else begin
          parse_phase = PH_BREAK;
          letters_first = 1'b0;
        end
      end
      default: begin
        if (is_digit) col_num = scale_add(col_num, RADIX_DEC, ch - CH_0);
      end
    endcase
    if (lst) begin
      conv_text.delete();
      if (letters_first) begin
        conv_text.push_back(CH_R);
        append_decimal(row_num);
        conv_text.push_back(CH_C);
        append_decimal(letter_col);
      end else begin
        append_letters(col_num);
        append_decimal(row_num);
      end
      n = (conv_text.size() > MAX_OUT_CHARS) ? MAX_OUT_CHARS : conv_text.size();
      for (int i = 0; i < n; i++) expected_chars.push_back('{conv_text[i], i == n - 1});
      parse_phase   = PH_LETTERS;
      letters_first = 1'b1;
      letter_col    = '0;
      row_num       = '0;
      col_num       = '0;
    end
  endtask

  // Predicts on every accepted request and checks every accepted output.
  always @(posedge clk) begin : monitor
    conv_char_t want;
    if (rst_n) begin
      if (in_valid && in_ready) predict_conversion(in_char_code, in_last_char);
      if (out_valid && out_ready) begin
        out_taken = 1'b1;
        results_seen++;
        if (expected_chars.size() == 0) begin
          errors++;
          $display("%0t: output with none expected: expected nothing, actual char %h last %b",
                   $time, out_char, out_last);
        end else begin
          want = expected_chars.pop_front();
          if (out_char !== want.ch) begin
            errors++;
            $display("%0t: out_char mismatch: expected %h actual %h",
                     $time, want.ch, out_char);
          end
          if (out_last !== want.last) begin
            errors++;
            $display("%0t: out_last mismatch: expected %b actual %b",
                     $time, want.last, out_last);
          end
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles = 0;
      else stall_cycles++;
    end
  end

  // Output side: a random gap after each accepted character, or one long hold.
  initial begin : receiver
    int rx_wait;
    out_ready = 1'b0;
    rx_wait   = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_taken = 1'b0;
        rx_wait = HOLD_CYCLES;
      end else if (out_taken) begin
        out_taken = 1'b0;
        rx_wait = rx_idle ? $urandom_range(0, 11) : 0;
      end
      if (rx_wait > 0) begin
        out_ready <= 1'b0;
        rx_wait--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    while (stall_cycles < WATCHDOG_LIMIT) @(negedge clk);
    $display("%0t: no handshake for %0d cycles, giving up", $time, WATCHDOG_LIMIT);
    $display("simulation failed");
    $finish;
  end

  // Called at a falling edge; returns at the falling edge after acceptance
  // with valid still high, so back-to-back requests need no second assignment.
  task automatic send_char(input logic [7:0] ch, input logic lst);
    int gap;
    gap = tx_idle ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_char_code <= ch;
    in_last_char <= lst;
    do @(posedge clk); while (!in_ready);
    chars_sent++;
    @(negedge clk);
  endtask

  task automatic send_reference();
    foreach (ref_text[i]) send_char(ref_text[i], i == ref_text.size() - 1);
    refs_sent++;
    ref_text.delete();
  endtask

  task automatic queue_text(input string s);
    for (int i = 0; i < s.len(); i++) ref_text.push_back(s[i]);
  endtask

  task automatic stop_input();
    in_valid <= 1'b0;
  endtask

  task automatic add_letters(input int n);
    repeat (n) ref_text.push_back(CH_A + 8'($urandom_range(0, 25)));
  endtask

  task automatic add_digits(input int n);
    repeat (n) ref_text.push_back(CH_0 + 8'($urandom_range(0, 9)));
  endtask

  // Mostly short fields; now and then long enough to saturate.
  function automatic int field_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(6, 8) : $urandom_range(1, 3);
  endfunction

  task automatic test_letters_digits();
    queue_text("A1");
    send_reference();
    queue_text("ZZZZZ9999999");
    send_reference();
    queue_text("7");
    send_reference();
    queue_text("C");
    send_reference();
  endtask

  task automatic test_row_column();
    // Zero row, Z by borrow, and a letter after the break that is ignored.
    queue_text("R0C5Z2");
    send_reference();
    ref_text.push_back(8'h00);
    send_reference();
    ref_text.push_back(8'hFF);
    send_reference();
  endtask

  task automatic test_backpressure();
    stop_input();
    @(posedge clk);
    hold_req = 1'b1;
    @(negedge clk);
    tx_idle = 1'b0;
    queue_text("ZZ99");
    send_reference();
    queue_text("R12C345");
    send_reference();
    queue_text("AB7");
    send_reference();
    tx_idle = 1'b1;
  endtask

  task automatic test_random_references();
    int kind;
    int stop_at;
    stop_at = chars_sent + RANDOM_CHARS;
    while (chars_sent < stop_at) begin
      kind = $urandom_range(0, 3);
      tx_idle = kind[0];
      rx_idle = kind[1];
      kind = $urandom_range(0, 19);
      if (kind < 9) begin
        add_letters(field_len());
        add_digits(field_len());
      end else if (kind < 16) begin
        ref_text.push_back(CH_R);
        add_digits(field_len());
        ref_text.push_back(CH_C);
        add_digits(field_len());
      end else if (kind < 18) begin
        add_letters($urandom_range(0, 2));
        add_digits($urandom_range(0, 2));
        ref_text.push_back(8'($urandom_range(0, 255)));
        add_letters($urandom_range(0, 2));
        add_digits($urandom_range(0, 3));
      end else begin
        repeat ($urandom_range(1, 6)) ref_text.push_back(8'($urandom_range(0, 255)));
      end
      send_reference();
    end
  endtask

  initial begin : stimulus
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_char_code  = 8'h00;
    in_last_char  = 1'b0;
    parse_phase   = PH_LETTERS;
    letters_first = 1'b1;
    letter_col    = '0;
    row_num       = '0;
    col_num       = '0;
    errors        = 0;
    chars_sent    = 0;
    refs_sent     = 0;
    results_seen  = 0;
    stall_cycles  = 0;
    tx_idle       = 1'b1;
    rx_idle       = 1'b1;
    hold_req      = 1'b0;
    out_taken     = 1'b0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_letters_digits();
    test_row_column();
    test_backpressure();
    test_random_references();

    stop_input();
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Converted %0d references (%0d input characters) into %0d output characters,",
             refs_sent, chars_sent, results_seen);
    $display("with random gaps on both sides and one long output hold-off.");
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
